// ===== rtl/dad_pkg.sv =====
// ============================================================================
// dad_pkg
// Shared types, constants and the month length table for the date adder.
// ============================================================================
package dad_pkg;

  // Width of the day count input.
  localparam int NIGHTS_WIDTH = 10;

  // The remaining count can grow by up to two days in the first month step
  // when the start day lies beyond the end of its month.
  localparam int REMAIN_W = NIGHTS_WIDTH + 1;

  // Signed working width for the compare against the room left in a month.
  localparam int STEP_W = (NIGHTS_WIDTH + 2 > 8) ? NIGHTS_WIDTH + 2 : 8;

  // Year limits and the split of the year into a century and a year in century.
  localparam logic [13:0] YEAR_LIMIT      = 14'd9999;
  localparam logic [6:0]  LAST_IN_CENT    = 7'd99;

  // Reciprocal of 100 scaled by 2^22; exact for every 14-bit year.
  localparam logic [15:0] RECIP_100       = 16'd41944;
  localparam int          RECIP_SHIFT     = 22;

  // Month codes.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_SPLIT,
    S_RUN,
    S_DONE
  } dad_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic divide;
    logic split;
    logic step;
  } dad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;
  } dad_stat_t;

  // Number of days in a month, given whether the year is a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/dad_ctrl.sv =====
// ============================================================================
// dad_ctrl
// Sequencer for the date adder: year split, month stepping and result strobe.
// ============================================================================
module dad_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dad_pkg::dad_stat_t stat,
  output dad_pkg::dad_cmd_t  cmd,
  output logic              busy,
  output logic              done
);

  dad_pkg::dad_state_t state;
  dad_pkg::dad_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dad_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      dad_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = dad_pkg::S_DIVIDE;
        end
      end
      dad_pkg::S_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = dad_pkg::S_SPLIT;
      end
      dad_pkg::S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = dad_pkg::S_RUN;
      end
      dad_pkg::S_RUN: begin
        if (stat.finished) begin
          state_next = dad_pkg::S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      dad_pkg::S_DONE: begin
        done       = 1'b1;
        state_next = dad_pkg::S_IDLE;
      end
      default: begin
        state_next = dad_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dad_datapath.sv =====
// ============================================================================
// dad_datapath
// Date registers, year split into century and year in century, and the
// one-month step unit.
// ============================================================================
module dad_datapath (
  input  logic                              clk,
  input  dad_pkg::dad_cmd_t                 cmd,
  input  logic [4:0]                        start_day,
  input  logic [3:0]                        start_month,
  input  logic [13:0]                       start_year,
  input  logic [dad_pkg::NIGHTS_WIDTH-1:0]  nights,
  output dad_pkg::dad_stat_t                stat,
  output logic [4:0]                        end_day,
  output logic [3:0]                        end_month,
  output logic [13:0]                       end_year,
  output logic                              year_overflow,
  output logic                              input_error
);

  logic [4:0]                    day;
  logic [3:0]                    month;
  logic [13:0]                   year;
  logic [dad_pkg::REMAIN_W-1:0]  remain;
  logic                          ovf;
  logic                          err;
  logic [7:0]                    quot;
  logic [6:0]                    y_lo;
  logic [7:0]                    y_hi;

  logic [29:0]                   prod;
  logic [14:0]                   cent_years;
  logic                          leap;
  logic [4:0]                    mlen;
  logic signed [6:0]             room;
  logic signed [dad_pkg::STEP_W-1:0] rem_x;
  logic signed [dad_pkg::STEP_W-1:0] room_x;
  logic signed [dad_pkg::STEP_W-1:0] rem_new;
  logic                          fits;

  // Century estimate by reciprocal multiply, and its times-100 by shifts.
  assign prod       = 30'(year) * 30'(dad_pkg::RECIP_100);
  assign cent_years = {1'b0, quot, 6'b0} + {2'b0, quot, 5'b0} + {5'b0, quot, 2'b0};

  // Gregorian leap rule from the year split: divisible by 4, and either not a
  // century year or a century divisible by 4.
  assign leap = (year[1:0] == 2'b00) && ((y_lo != 7'd0) || (y_hi[1:0] == 2'b00));

  // Room left in the current month and whether the remaining count fits.
  assign mlen    = dad_pkg::month_len(month, leap);
  assign room    = $signed({2'b00, mlen}) - $signed({2'b00, day});
  assign rem_x   = $signed(dad_pkg::STEP_W'(remain));
  assign room_x  = dad_pkg::STEP_W'(room);
  assign fits    = rem_x <= room_x;
  assign rem_new = rem_x - room_x - dad_pkg::STEP_W'(1);

  assign stat.finished = err || (remain == '0);

  // Load, split and month step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day    <= start_day;
      month  <= start_month;
      year   <= start_year;
      remain <= dad_pkg::REMAIN_W'(nights);
      ovf    <= 1'b0;
      err    <= (start_day == 5'd0) || (start_month == 4'd0) ||
                (start_month > dad_pkg::MONTH_DEC);
    end else if (cmd.divide) begin
      quot <= prod[dad_pkg::RECIP_SHIFT +: 8];
    end else if (cmd.split) begin
      y_lo <= 7'(15'(year) - cent_years);
      y_hi <= quot;
    end else if (cmd.step) begin
      if (fits) begin
        day    <= day + 5'(remain);
        remain <= '0;
      end else begin
        remain <= dad_pkg::REMAIN_W'(rem_new);
        day    <= 5'd1;
        if (month == dad_pkg::MONTH_DEC) begin
          month <= dad_pkg::MONTH_JAN;
          // Year increment with wrap past the last year.
          if (year >= dad_pkg::YEAR_LIMIT) begin
            year <= '0;
            ovf  <= 1'b1;
            y_lo <= '0;
            y_hi <= '0;
          end else begin
            year <= year + 14'd1;
            if (y_lo == dad_pkg::LAST_IN_CENT) begin
              y_lo <= '0;
              y_hi <= y_hi + 8'd1;
            end else begin
              y_lo <= y_lo + 7'd1;
            end
          end
        end else begin
          month <= month + 4'd1;
        end
      end
    end
  end

  assign end_day       = day;
  assign end_month     = month;
  assign end_year      = year;
  assign year_overflow = ovf;
  assign input_error   = err;

endmodule

// ===== rtl/date_add_days_unit.sv =====
// ============================================================================
// date_add_days_unit
// Gregorian date plus a count of days, stepped one month at a time.
// ============================================================================
// An item is taken when start is high and busy is low; one result follows,
// shown on the end_* ports, year_overflow and input_error for the single cycle
// in which done is high, and the receiver must take it then. After the
// accepting edge the sequencer passes through S_DIVIDE and S_SPLIT, which
// split the year into century and year in century, then S_RUN, where the
// month step unit takes one step for each month boundary crossed plus one
// more when the count ends inside a month, until S_RUN sees that the count
// is used up; S_DONE then shows the result. An invalid start date or a zero
// count takes no month step. busy stays high from the accepting edge
// through the done cycle, and the next item can be taken at the edge that
// ends the following cycle.
module date_add_days_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [4:0]                        start_day,
  input  logic [3:0]                        start_month,
  input  logic [13:0]                       start_year,
  input  logic [dad_pkg::NIGHTS_WIDTH-1:0]  nights,
  output logic                              done,
  output logic [4:0]                        end_day,
  output logic [3:0]                        end_month,
  output logic [13:0]                       end_year,
  output logic                              year_overflow,
  output logic                              input_error
);

  dad_pkg::dad_cmd_t  cmd;
  dad_pkg::dad_stat_t stat;

  // Sequencer.
  dad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Date registers and month step unit.
  dad_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .nights        (nights),
    .stat          (stat),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .year_overflow (year_overflow),
    .input_error   (input_error)
  );

  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // After the result cycle the block is free again.
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block still busy after the result cycle");

  // A valid start date always ends on a real month and a nonzero day.
  a_valid_result: assert property (@(posedge clk) disable iff (rst)
    done && !input_error |-> end_month >= dad_pkg::MONTH_JAN &&
                             end_month <= dad_pkg::MONTH_DEC &&
                             end_day != 5'd0)
    else $error("result date out of range");

  // An invalid start date never reports a year overflow.
  a_error_no_ovf: assert property (@(posedge clk) disable iff (rst)
    done && input_error |-> !year_overflow)
    else $error("overflow reported on an invalid start date");

endmodule

// ===== dv/date_add_days_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// date_add_days_checker
// Watches the item and result ports of the date adder, predicts each result
// from the accepted item and compares the two field by field.
// ============================================================================
module date_add_days_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [4:0]                        start_day,
  input  logic [3:0]                        start_month,
  input  logic [13:0]                       start_year,
  input  logic [dad_pkg::NIGHTS_WIDTH-1:0]  nights,
  input  logic                              done,
  input  logic [4:0]                        end_day,
  input  logic [3:0]                        end_month,
  input  logic [13:0]                       end_year,
  input  logic                              year_overflow,
  input  logic                              input_error,
  output int                                failures,
  output int                                outstanding
);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        ovf;
    logic        err;
  } date_result_t;

  // Results predicted for accepted items, oldest first.
  date_result_t expected_dates[$];

  // Walk the calendar one month at a time until the day count is used up.
  function automatic date_result_t add_nights(input logic [4:0] d, input logic [3:0] m,
                                              input logic [13:0] y,
                                              input logic [dad_pkg::NIGHTS_WIDTH-1:0] n);
    date_result_t r;
    int day;
    int month;
    int year;
    int left;
    int mlen;
    bit leap;
    r = '0;
    day = d;
    month = m;
    year = y;
    left = n;
    if (d == 0 || m == 0 || m > dad_pkg::MONTH_DEC) begin
      // An invalid start date is passed through with the error flag.
      r.err = 1'b1;
    end else begin
      while (left > 0) begin
        leap = ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
        case (month) inside
          dad_pkg::MONTH_APR, dad_pkg::MONTH_JUN,
          dad_pkg::MONTH_SEP, dad_pkg::MONTH_NOV: mlen = 30;
          dad_pkg::MONTH_FEB: mlen = leap ? 29 : 28;
          default: mlen = 31;
        endcase
        // A start day past the month end gives negative room here.
        if (left <= mlen - day) begin
          day += left;
          left = 0;
        end else begin
          left -= mlen - day + 1;
          day = 1;
          month++;
          if (month > dad_pkg::MONTH_DEC) begin
            month = dad_pkg::MONTH_JAN;
            year++;
            if (year > dad_pkg::YEAR_LIMIT) begin
              year = 0;
              r.ovf = 1'b1;
            end
          end
        end
      end
    end
    r.day = day[4:0];
    r.month = month[3:0];
    r.year = year[13:0];
    return r;
  endfunction

  initial begin
    failures = 0;
    outstanding = 0;
  end

  // Predict on every accepted item and check every strobed result.
  always @(posedge clk) begin : watch
    date_result_t want;
    if (!rst) begin
      if (start && !busy) begin
        expected_dates.push_back(add_nights(start_day, start_month, start_year, nights));
      end
      if (done) begin
        if (expected_dates.size() == 0) begin
          $error("result with no item pending: %0d/%0d/%0d", end_day, end_month, end_year);
          failures++;
        end else begin
          want = expected_dates.pop_front();
          if (end_day !== want.day) begin
            $error("end_day: expected %0d, got %0d", want.day, end_day);
            failures++;
          end
          if (end_month !== want.month) begin
            $error("end_month: expected %0d, got %0d", want.month, end_month);
            failures++;
          end
          if (end_year !== want.year) begin
            $error("end_year: expected %0d, got %0d", want.year, end_year);
            failures++;
          end
          if (year_overflow !== want.ovf) begin
            $error("year_overflow: expected %0b, got %0b", want.ovf, year_overflow);
            failures++;
          end
          if (input_error !== want.err) begin
            $error("input_error: expected %0b, got %0b", want.err, input_error);
            failures++;
          end
        end
      end
      outstanding = expected_dates.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Top of the date adder test: drives directed and random dates in bursts.
// ============================================================================
// A short directed list covers leap rules, the day past month end, invalid
// dates, zero counts and the year wrap; random items follow in bursts with
// random gaps. The checker beside the block predicts and compares results.
module tb;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 500000;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [4:0]                        start_day;
  logic [3:0]                        start_month;
  logic [13:0]                       start_year;
  logic [dad_pkg::NIGHTS_WIDTH-1:0]  nights;
  logic                              done;
  logic [4:0]                        end_day;
  logic [3:0]                        end_month;
  logic [13:0]                       end_year;
  logic                              year_overflow;
  logic                              input_error;
  int                                failures;
  int                                outstanding;
  int                                cycles;

  date_add_days_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_day(start_day), .start_month(start_month), .start_year(start_year),
    .nights(nights), .done(done), .end_day(end_day), .end_month(end_month),
    .end_year(end_year), .year_overflow(year_overflow), .input_error(input_error)
  );

  date_add_days_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_day(start_day), .start_month(start_month), .start_year(start_year),
    .nights(nights), .done(done), .end_day(end_day), .end_month(end_month),
    .end_year(end_year), .year_overflow(year_overflow), .input_error(input_error),
    .failures(failures), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on the total run length.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_date(input logic [4:0] d, input logic [3:0] m,
                           input logic [13:0] y,
                           input logic [dad_pkg::NIGHTS_WIDTH-1:0] n);
    @(negedge clk);
    start <= 1'b1;
    start_day <= d;
    start_month <= m;
    start_year <= y;
    nights <= n;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a number of cycles, with noise on the fields.
  task automatic idle_for(input int count);
    @(negedge clk);
    start <= 1'b0;
    start_day <= 5'($urandom);
    start_month <= 4'($urandom);
    start_year <= 14'($urandom);
    nights <= dad_pkg::NIGHTS_WIDTH'($urandom);
    repeat (count - 1) @(negedge clk);
  endtask

  // Random item, mostly valid dates with years near the interesting edges.
  task automatic send_random_date();
    logic [4:0]                       d;
    logic [3:0]                       m;
    logic [13:0]                      y;
    logic [dad_pkg::NIGHTS_WIDTH-1:0] n;
    int                               pick;
    d = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    if ($urandom_range(0, 15) == 0) begin
      pick = $urandom_range(0, 3);
      m = (pick == 0) ? 4'd0 : 4'(12 + pick);
    end else begin
      m = 4'($urandom_range(1, 12));
    end
    case ($urandom_range(0, 19))
      0, 1, 2: y = 14'($urandom_range(9990, 9999));
      3, 4:    y = 14'($urandom_range(0, 99) * 100);
      5:       y = 14'($urandom_range(10000, 16383));
      default: y = 14'($urandom_range(0, 9999));
    endcase
    case ($urandom_range(0, 9))
      0:       n = '0;
      1:       n = '1;
      2, 3:    n = dad_pkg::NIGHTS_WIDTH'($urandom_range(0, 40));
      default: n = dad_pkg::NIGHTS_WIDTH'($urandom);
    endcase
    send_date(d, m, y, n);
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    rst = 1'b1;
    start = 1'b0;
    start_day = '0;
    start_month = '0;
    start_year = '0;
    nights = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items: leap rules, days past month end, invalid dates, wraps.
    send_date(5'd1, 4'd1, 14'd2000, 10'd0);
    send_date(5'd31, 4'd12, 14'd9999, 10'd1);
    send_date(5'd28, 4'd2, 14'd2000, 10'd1);
    send_date(5'd28, 4'd2, 14'd1900, 10'd1);
    send_date(5'd28, 4'd2, 14'd2024, 10'd1);
    send_date(5'd28, 4'd2, 14'd2023, 10'd1);
    send_date(5'd31, 4'd4, 14'd2021, 10'd1);
    send_date(5'd31, 4'd4, 14'd2021, 10'd0);
    send_date(5'd30, 4'd2, 14'd2021, 10'd5);
    send_date(5'd31, 4'd2, 14'd2020, 10'd1);
    send_date(5'd0, 4'd5, 14'd2020, 10'd10);
    send_date(5'd15, 4'd0, 14'd2020, 10'd10);
    send_date(5'd15, 4'd13, 14'd2020, 10'd10);
    send_date(5'd31, 4'd15, 14'd16383, 10'd1023);
    send_date(5'd1, 4'd1, 14'd0, 10'd1023);
    send_date(5'd31, 4'd12, 14'd16383, 10'd1);
    send_date(5'd15, 4'd6, 14'd12000, 10'd3);
    send_date(5'd1, 4'd12, 14'd9999, 10'd1023);
    send_date(5'd31, 4'd1, 14'd2000, 10'd29);
    send_date(5'd1, 4'd3, 14'd2100, 10'd1023);
    send_date(5'd31, 4'd12, 14'd2399, 10'd60);
    send_date(5'd0, 4'd0, 14'd0, 10'd0);
    send_date(5'd31, 4'd1, 14'd0, 10'd1);
    send_date(5'd31, 4'd12, 14'd9998, 10'd366);

    // Let the pipe drain completely before the random part.
    idle_for(1);
    wait (outstanding == 0);

    // Random items in bursts, some bursts back to back.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_random_date();
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
        idle_for(1);
        wait (outstanding == 0);
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 45));
      end
    end

    idle_for(1);
    wait (outstanding == 0);
    repeat (50) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dad_pkg.sv
rtl/dad_ctrl.sv
rtl/dad_datapath.sv
rtl/date_add_days_unit.sv
dv/date_add_days_checker.sv
dv/tb.sv
